### rtl/mips_tlb_address_translation_macros.svh
// Assertion macros for the MMU controller RTL
`ifndef MIPS_TLB_ADDRESS_TRANSLATION_MACROS_SVH
`define MIPS_TLB_ADDRESS_TRANSLATION_MACROS_SVH

// Implication checked on the next clock edge
`define MTLB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("MMU next-cycle check failed");

// Implication checked on the same clock edge
`define MTLB_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("MMU same-cycle check failed");

`endif

### rtl/mtlb_pkg.sv
// Types and constants of the MIPS TLB address translation block
package mtlb_pkg;

  typedef enum logic [2:0] {
    OP_READ   = 3'd0,
    OP_WRITE  = 3'd1,
    OP_FETCH  = 3'd2,
    OP_WR_ENT = 3'd3,
    OP_RD_ENT = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    EXC_NONE    = 3'd0,
    EXC_ADDR    = 3'd1,
    EXC_MISS    = 3'd2,
    EXC_XMISS   = 3'd3,
    EXC_INVALID = 3'd4,
    EXC_MOD     = 3'd5
  } exc_e;

  typedef enum logic [2:0] {
    CFG_KSU   = 3'd0,
    CFG_ERL   = 3'd1,
    CFG_EXL   = 3'd2,
    CFG_KX    = 3'd3,
    CFG_SX    = 3'd4,
    CFG_UX    = 3'd5,
    CFG_ASID  = 3'd6
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  localparam logic [63:0] Vpn2Field = 64'h0000_00FF_FFFF_E000;
  localparam logic [63:0] HiKeep    = 64'hC000_00FF_FFFF_E0FF;
  localparam logic [24:0] MaskKeep  = 25'h1FF_E000;

  typedef struct packed {
    logic [63:0] hi;
    logic [25:0] lo_even;
    logic [25:0] lo_odd;
    logic [24:0] pm;
    logic        g;
  } entry_t;

  localparam entry_t EntryReset = '{
    hi:      64'h0000_00FF_FFFF_E0FF,
    lo_even: 26'd0,
    lo_odd:  26'd0,
    pm:      25'd0,
    g:       1'b1
  };

  typedef struct packed {
    logic capture;
    logic decode;
    logic rd_en;
    logic rd_search;
    logic cnt_clr;
    logic cnt_inc;
    logic check;
    logic wr_entry;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic is_xlate;
    logic is_wr_ent;
    logic is_rd_ent;
    logic need_lookup;
    logic idx_ok;
    logic hit;
    logic last;
    logic out_free;
  } sts_t;

endpackage

### rtl/mtlb_req_if.sv
// Request channel: one translation or TLB maintenance request per transfer
interface mtlb_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [63:0] vaddr;
  logic [1:0]  size_log2;
  logic        aligned_access;
  logic [4:0]  entry_index;
  logic [25:0] lo_even;
  logic [25:0] lo_odd;
  logic [63:0] hi_value;
  logic [24:0] mask_value;

  modport source (output valid, opcode, vaddr, size_log2, aligned_access, entry_index,
                  lo_even, lo_odd, hi_value, mask_value, input ready);
  modport sink   (input valid, opcode, vaddr, size_log2, aligned_access, entry_index,
                  lo_even, lo_odd, hi_value, mask_value, output ready);
endinterface

### rtl/mtlb_rsp_if.sv
// Response channel: one result per request
interface mtlb_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] paddr;
  logic        cacheable;
  logic [2:0]  exc_code;
  logic [25:0] rd_lo_even;
  logic [25:0] rd_lo_odd;
  logic [63:0] rd_hi;
  logic [24:0] rd_mask;

  modport source (output valid, paddr, cacheable, exc_code, rd_lo_even, rd_lo_odd,
                  rd_hi, rd_mask, input ready);
  modport sink   (input valid, paddr, cacheable, exc_code, rd_lo_even, rd_lo_odd,
                  rd_hi, rd_mask, output ready);
endinterface

### rtl/mips_tlb_address_translation.sv
// MIPS R4300-style MMU: alignment check, segment decode, and an ENTRY_COUNT-entry
// joint TLB held in a single-port entry store. A request is taken and decoded the next
// cycle; for unmapped segments, address errors and TLB writes the result then goes to
// the output register, while a TLB read first reads the entry store. A mapped access
// scans the entries from index 0, a store read and then a compare for each entry,
// and stops at the first match or, on a miss, after the last entry. The result sits in
// an output register, loaded once it is free; the next request is taken as soon as the
// controller is back in idle, even while the previous result waits. Configuration
// writes take effect at the next edge.
module mips_tlb_address_translation import mtlb_pkg::*; #(
  parameter int unsigned ENTRY_COUNT = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  mtlb_req_if.sink            req_i,
  mtlb_rsp_if.source          rsp_o
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign req_i.ready = in_ready;

  mtlb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mtlb_dp #(
    .ENTRY_COUNT (ENTRY_COUNT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .rsp_o       (rsp_o)
  );

endmodule

### rtl/mtlb_dp.sv
// Datapath: request registers, segment decode, TLB entry store, compare and result register
module mtlb_dp import mtlb_pkg::*; #(
  parameter int unsigned ENTRY_COUNT = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  mtlb_req_if.sink            req_i,
  mtlb_rsp_if.source          rsp_o
);

  localparam int unsigned AW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

  // configuration
  logic [1:0] ksu_q;
  logic       erl_q, exl_q, kx_q, sx_q, ux_q;
  logic [7:0] asid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ksu_q  <= 2'd0;
      erl_q  <= 1'b1;
      exl_q  <= 1'b0;
      kx_q   <= 1'b0;
      sx_q   <= 1'b0;
      ux_q   <= 1'b0;
      asid_q <= 8'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_KSU:  ksu_q  <= cfg_wdata_i[1:0];
        CFG_ERL:  erl_q  <= cfg_wdata_i[0];
        CFG_EXL:  exl_q  <= cfg_wdata_i[0];
        CFG_KX:   kx_q   <= cfg_wdata_i[0];
        CFG_SX:   sx_q   <= cfg_wdata_i[0];
        CFG_UX:   ux_q   <= cfg_wdata_i[0];
        CFG_ASID: asid_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // request capture, alignment handled on the way in
  logic [2:0]  op_q;
  logic [63:0] va_q;
  logic        aerr_q;
  logic [4:0]  idx_q;
  logic [25:0] le_q, lodd_q;
  logic [63:0] hiv_q;
  logic [24:0] pmv_q;

  logic [2:0]  size_mask;
  logic [63:0] va_eff;
  logic        aerr_in;

  always_comb begin
    case (req_i.size_log2)
      2'd0:    size_mask = 3'b000;
      2'd1:    size_mask = 3'b001;
      2'd2:    size_mask = 3'b011;
      default: size_mask = 3'b111;
    endcase
    aerr_in = (req_i.opcode == OP_READ || req_i.opcode == OP_WRITE) &&
              req_i.aligned_access && (|(req_i.vaddr[2:0] & size_mask));
    va_eff  = req_i.vaddr;
    if (req_i.opcode == OP_READ && !req_i.aligned_access) begin
      va_eff[2:0] = req_i.vaddr[2:0] & ~size_mask;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture && req_i.valid) begin
      op_q   <= req_i.opcode;
      va_q   <= va_eff;
      aerr_q <= aerr_in;
      idx_q  <= req_i.entry_index;
      le_q   <= req_i.lo_even;
      lodd_q <= req_i.lo_odd;
      hiv_q  <= req_i.hi_value;
      pmv_q  <= req_i.mask_value;
    end
  end

  logic is_xlate, is_wr_ent, is_rd_ent, is_store, idx_ok;
  assign is_xlate  = (op_q == OP_READ) || (op_q == OP_WRITE) || (op_q == OP_FETCH);
  assign is_wr_ent = (op_q == OP_WR_ENT);
  assign is_rd_ent = (op_q == OP_RD_ENT);
  assign is_store  = (op_q == OP_WRITE);
  assign idx_ok    = (32'(idx_q) < ENTRY_COUNT);

  // segment decode
  logic        kern, sup, wide, use_k32, dec_lookup, dec_cach;
  logic [63:0] dec_va, va_sx;
  logic [31:0] dec_pa;
  exc_e        dec_exc;

  always_comb begin
    kern       = (ksu_q == 2'd0) || erl_q || exl_q;
    sup        = !kern && (ksu_q == 2'd1);
    wide       = kern ? kx_q : (sup ? sx_q : ux_q);
    va_sx      = {{32{va_q[31]}}, va_q[31:0]};
    use_k32    = 1'b0;
    dec_lookup = 1'b0;
    dec_va     = va_q;
    dec_cach   = 1'b0;
    dec_pa     = 32'd0;
    dec_exc    = EXC_NONE;
    if (kern) begin
      if (!wide) begin
        use_k32 = 1'b1;
      end else begin
        case (va_q[63:60])
          4'h0: begin
            if (va_q <= 64'h0000_00FF_FFFF_FFFF) dec_lookup = 1'b1;
            else dec_exc = EXC_ADDR;
          end
          4'h4: begin
            if (va_q <= 64'h4000_00FF_FFFF_FFFF) dec_lookup = 1'b1;
            else dec_exc = EXC_ADDR;
          end
          4'h8, 4'h9, 4'hA, 4'hB: begin
            if ((va_q & 64'h07FF_FFFF_0000_0000) != 64'd0) begin
              dec_exc = EXC_ADDR;
            end else begin
              dec_cach = ((va_q & 64'h9800_0000_0000_0000) != 64'h9000_0000_0000_0000);
              dec_pa   = va_q[31:0];
            end
          end
          4'hC: begin
            if (va_q <= 64'hC000_00FF_7FFF_FFFF) dec_lookup = 1'b1;
            else dec_exc = EXC_ADDR;
          end
          4'hF: begin
            if (va_q >= 64'hFFFF_FFFF_8000_0000) use_k32 = 1'b1;
            else dec_exc = EXC_ADDR;
          end
          default: dec_exc = EXC_ADDR;
        endcase
      end
      if (use_k32) begin
        case (va_q[31:29])
          3'b100: begin
            dec_cach = 1'b1;
            dec_pa   = {3'b000, va_q[28:0]};
          end
          3'b101:  dec_pa = {3'b000, va_q[28:0]};
          default: begin
            dec_lookup = 1'b1;
            dec_va     = va_sx;
          end
        endcase
      end
    end else if (sup) begin
      if (!wide) begin
        if (va_q[31] && va_q[30:29] != 2'b10) begin
          dec_exc = EXC_ADDR;
        end else begin
          dec_lookup = 1'b1;
          dec_va     = va_sx;
        end
      end else if ((va_q[63:60] == 4'h0 && va_q <= 64'h0000_00FF_FFFF_FFFF) ||
                   (va_q[63:60] == 4'h4 && va_q <= 64'h4000_00FF_FFFF_FFFF) ||
                   ((va_q & 64'hFFFF_FFFF_E000_0000) == 64'hFFFF_FFFF_C000_0000)) begin
        dec_lookup = 1'b1;
      end else begin
        dec_exc = EXC_ADDR;
      end
    end else begin
      if (!wide) begin
        if (va_q[31]) begin
          dec_exc = EXC_ADDR;
        end else begin
          dec_lookup = 1'b1;
          dec_va     = va_sx;
        end
      end else if (va_q < 64'h0000_0100_0000_0000) begin
        dec_lookup = 1'b1;
      end else begin
        dec_exc = EXC_ADDR;
      end
    end
  end

  // lookup context and working result
  logic [63:0] lva_q;
  logic        wide_q, wr_q;
  logic [31:0] res_pa_q;
  logic        res_cach_q;
  exc_e        res_exc_q;

  // entry store
  entry_t          mem_q [ENTRY_COUNT];
  logic [ENTRY_COUNT-1:0] vld_q;
  entry_t          rdata_q;
  logic            rvld_q;
  logic [AW-1:0]   cnt_q;
  logic [6:0]      idx_ext;
  logic [AW-1:0]   idx_addr, raddr;
  entry_t          wdata, ent;

  assign idx_ext  = 7'(idx_q);
  assign idx_addr = idx_ext[AW-1:0];
  assign raddr    = cmd_i.rd_search ? cnt_q : idx_addr;

  always_comb begin
    wdata.pm      = pmv_q & MaskKeep;
    wdata.lo_even = le_q;
    wdata.lo_odd  = lodd_q;
    wdata.hi      = hiv_q & HiKeep & ~{39'd0, wdata.pm};
    wdata.g       = le_q[0] & lodd_q[0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_entry && idx_ok) begin
      mem_q[idx_addr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (cmd_i.wr_entry && idx_ok) vld_q[idx_addr] <= 1'b1;
      if (cmd_i.rd_en) rvld_q <= vld_q[raddr];
      if (cmd_i.cnt_clr) cnt_q <= '0;
      else if (cmd_i.cnt_inc) cnt_q <= cnt_q + 1'b1;
    end
  end

  assign ent = rvld_q ? rdata_q : EntryReset;

  // entry compare
  logic [63:0] vmask;
  logic [24:0] omask, osel;
  logic [25:0] lo_sel;
  logic [31:0] hit_pa;
  logic        hit;
  exc_e        hit_exc;

  always_comb begin
    vmask   = Vpn2Field & ~{39'd0, ent.pm};
    hit     = (((lva_q ^ ent.hi) & vmask) == 64'd0) &&
              (ent.g || ent.hi[7:0] == asid_q) &&
              (lva_q[63:62] == ent.hi[63:62]);
    omask   = {1'b0, ent.pm[24:1]} | 25'h000_0FFF;
    osel    = omask + 25'd1;
    lo_sel  = (|(lva_q[24:0] & osel)) ? ent.lo_odd : ent.lo_even;
    hit_exc = EXC_NONE;
    if (!lo_sel[1]) hit_exc = EXC_INVALID;
    else if (wr_q && !lo_sel[2]) hit_exc = EXC_MOD;
    hit_pa  = ({7'd0, omask} & lva_q[31:0]) | ({lo_sel[25:6], 12'd0} & ~{7'd0, omask});
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decode) begin
      lva_q      <= dec_va;
      wide_q     <= wide;
      wr_q       <= is_store;
      res_pa_q   <= 32'd0;
      res_cach_q <= 1'b0;
      res_exc_q  <= EXC_NONE;
      if (is_xlate) begin
        if (aerr_q) begin
          res_exc_q <= EXC_ADDR;
        end else if (!dec_lookup) begin
          res_exc_q  <= dec_exc;
          res_pa_q   <= dec_pa;
          res_cach_q <= dec_cach;
        end
      end
    end else if (cmd_i.check) begin
      res_cach_q <= 1'b0;
      if (hit) begin
        res_exc_q <= hit_exc;
        res_pa_q  <= (hit_exc == EXC_NONE) ? hit_pa : 32'd0;
      end else begin
        res_exc_q <= wide_q ? EXC_XMISS : EXC_MISS;
        res_pa_q  <= 32'd0;
      end
    end
  end

  // output register
  logic out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      rsp_o.paddr      <= 32'd0;
      rsp_o.cacheable  <= 1'b0;
      rsp_o.exc_code   <= EXC_NONE;
      rsp_o.rd_lo_even <= 26'd0;
      rsp_o.rd_lo_odd  <= 26'd0;
      rsp_o.rd_hi      <= 64'd0;
      rsp_o.rd_mask    <= 25'd0;
      if (is_xlate) begin
        rsp_o.paddr     <= res_pa_q;
        rsp_o.cacheable <= res_cach_q;
        rsp_o.exc_code  <= res_exc_q;
      end else if (is_rd_ent && idx_ok) begin
        rsp_o.rd_lo_even <= {ent.lo_even[25:1], ent.g};
        rsp_o.rd_lo_odd  <= {ent.lo_odd[25:1], ent.g};
        rsp_o.rd_hi      <= ent.hi & ~{39'd0, ent.pm};
        rsp_o.rd_mask    <= ent.pm;
      end
    end
  end

  assign rsp_o.valid = out_vld_q;

  always_comb begin
    sts_o.is_xlate    = is_xlate;
    sts_o.is_wr_ent   = is_wr_ent;
    sts_o.is_rd_ent   = is_rd_ent;
    sts_o.need_lookup = !aerr_q && dec_lookup;
    sts_o.idx_ok      = idx_ok;
    sts_o.hit         = hit;
    sts_o.last        = (32'(cnt_q) == ENTRY_COUNT - 1);
    sts_o.out_free    = !out_vld_q || rsp_o.ready;
  end

endmodule

### rtl/mtlb_ctrl.sv
// Controller: sequences decode, entry scan, entry write/read and result hand-off
`include "mips_tlb_address_translation_macros.svh"

module mtlb_ctrl import mtlb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DECODE = 5'b00010,
    ST_READ   = 5'b00100,
    ST_CHECK  = 5'b01000,
    ST_FINISH = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = 1'b1;
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        cmd_o.decode = 1'b1;
        if (sts_i.is_xlate && sts_i.need_lookup) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = ST_READ;
        end else if (sts_i.is_wr_ent) begin
          cmd_o.wr_entry = 1'b1;
          state_d        = ST_FINISH;
        end else if (sts_i.is_rd_ent && sts_i.idx_ok) begin
          state_d = ST_READ;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_READ: begin
        cmd_o.rd_en     = 1'b1;
        cmd_o.rd_search = sts_i.is_xlate;
        state_d         = sts_i.is_xlate ? ST_CHECK : ST_FINISH;
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        if (sts_i.hit || sts_i.last) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.cnt_inc = 1'b1;
          state_d       = ST_READ;
        end
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  `MTLB_ASSERT_NEXT(a_accept_decodes, state_q == ST_IDLE && in_valid_i, state_q == ST_DECODE)
  `MTLB_ASSERT_NEXT(a_scan_continues,
                    state_q == ST_CHECK && !sts_i.hit && !sts_i.last, state_q == ST_READ)
  `MTLB_ASSERT_SAME(a_load_when_free, cmd_o.load_out, sts_i.out_free && state_q == ST_FINISH)
  `MTLB_ASSERT_NEXT(a_finish_returns, state_q == ST_FINISH && sts_i.out_free, state_q == ST_IDLE)

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the MIPS TLB address translation block
`timescale 1ns / 100ps

module tb_top import mtlb_pkg::*; ();

  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] va;
    logic [1:0]  size;
    logic        al;
    logic [4:0]  idx;
    logic [25:0] le;
    logic [25:0] lo;
    logic [63:0] hi;
    logic [24:0] mask;
  } req_t;

  typedef struct packed {
    logic [31:0] paddr;
    logic        cach;
    logic [2:0]  exc;
    logic [25:0] rle;
    logic [25:0] rlo;
    logic [63:0] rhi;
    logic [24:0] rmask;
  } rsp_t;

  typedef struct packed {
    logic typed;
    rsp_t ex;
  } hand_t;

  typedef struct packed {
    req_t rq;
    logic typed;
    rsp_t ex;
  } drow_t;

  typedef struct packed {
    logic [1:0] ksu;
    logic       erl;
    logic       exl;
    logic       kx;
    logic       sx;
    logic       ux;
    logic [7:0] asid;
  } mode_t;

  localparam rsp_t NoRsp = '0;
  localparam logic [63:0] KsegBase = 64'hFFFF_FFFF_8000_0000;
  localparam logic [24:0] PageMasks [7] = '{25'h0000000, 25'h0006000, 25'h001E000,
      25'h007E000, 25'h01FE000, 25'h07FE000, 25'h1FFE000};
  localparam logic [63:0] EdgeAddrs [11] = '{64'h0000_00FF_FFFF_FFFF,
      64'h0000_0100_0000_0000, 64'h4000_00FF_FFFF_FFFF, 64'hC000_00FF_7FFF_FFFF,
      64'hC000_00FF_8000_0000, 64'hFFFF_FFFF_8000_0000, 64'hFFFF_FFFF_7FFF_FFFF,
      64'hFFFF_FFFF_C000_0000, 64'hFFFF_FFFF_E000_0000, 64'h0000_0000_7FFF_FFFF,
      64'h0000_0000_8000_0000};

  localparam int NumRows = 22;
  localparam drow_t DirRows [NumRows] = '{
    '{'{OP_RD_ENT, 64'd0, 2'd0, 1'b0, 5'd0, 26'd0, 26'd0, 64'd0, 25'd0}, 1'b1,
      '{32'd0, 1'b0, EXC_NONE, 26'd1, 26'd1, 64'h0000_00FF_FFFF_E0FF, 25'd0}},
    '{'{OP_RD_ENT, 64'd0, 2'd0, 1'b0, 5'd31, 26'd0, 26'd0, 64'd0, 25'd0}, 1'b1,
      '{32'd0, 1'b0, EXC_NONE, 26'd1, 26'd1, 64'h0000_00FF_FFFF_E0FF, 25'd0}},
    '{'{OP_READ, KsegBase, 2'd0, 1'b1, 5'd0, 26'd0, 26'd0, 64'd0, 25'd0}, 1'b1,
      '{32'd0, 1'b1, EXC_NONE, 26'd0, 26'd0, 64'd0, 25'd0}},
    '{'{OP_READ, 64'hFFFF_FFFF_A000_1234, 2'd2, 1'b1, 5'd0, 26'd0, 26'd0, 64'd0, 25'd0},
      1'b1, '{32'h1234, 1'b0, EXC_NONE, 26'd0, 26'd0, 64'd0, 25'd0}},
    '{'{OP_READ, 64'd1, 2'd3, 1'b1, 5'd0, 26'd0, 26'd0, 64'd0, 25'd0}, 1'b1,
      '{32'd0, 1'b0, EXC_ADDR, 26'd0, 26'd0, 64'd0, 25'd0}},
    '{'{OP_WRITE, 64'd2, 2'd2, 1'b1, 5'd0, 26'd0, 26'd0, 64'd0, 25'd0}, 1'b1,
      '{32'd0, 1'b0, EXC_ADDR, 26'd0, 26'd0, 64'd0, 25'd0}},
    '{'{OP_FETCH, 64'hFFFF_FFFF_BFC0_0001, 2'd3, 1'b1, 5'd0, 26'd0, 26'd0, 64'd0, 25'd0},
      1'b1, '{32'h1FC0_0001, 1'b0, EXC_NONE, 26'd0, 26'd0, 64'd0, 25'd0}},
    '{'{OP_READ, 64'hFFFF_FFFF_8000_0007, 2'd3, 1'b0, 5'd0, 26'd0, 26'd0, 64'd0, 25'd0},
      1'b1, '{32'd0, 1'b1, EXC_NONE, 26'd0, 26'd0, 64'd0, 25'd0}},
    '{'{OP_WRITE, 64'hFFFF_FFFF_8000_0007, 2'd3, 1'b0, 5'd0, 26'd0, 26'd0, 64'd0, 25'd0},
      1'b1, '{32'd7, 1'b1, EXC_NONE, 26'd0, 26'd0, 64'd0, 25'd0}},
    // even page valid but clean, odd page invalid
    '{'{OP_WR_ENT, 64'd0, 2'd0, 1'b0, 5'd0, 26'h48C2, 26'd0, 64'h2000, 25'd0}, 1'b0, NoRsp},
    '{'{OP_READ, 64'h2010, 2'd0, 1'b1, 5'd0, 26'd0, 26'd0, 64'd0, 25'd0}, 1'b0, NoRsp},
    '{'{OP_WRITE, 64'h2010, 2'd0, 1'b1, 5'd0, 26'd0, 26'd0, 64'd0, 25'd0}, 1'b1,
      '{32'd0, 1'b0, EXC_MOD, 26'd0, 26'd0, 64'd0, 25'd0}},
    '{'{OP_READ, 64'h3010, 2'd0, 1'b1, 5'd0, 26'd0, 26'd0, 64'd0, 25'd0}, 1'b1,
      '{32'd0, 1'b0, EXC_INVALID, 26'd0, 26'd0, 64'd0, 25'd0}},
    '{'{OP_READ, 64'h7000_0000, 2'd0, 1'b1, 5'd0, 26'd0, 26'd0, 64'd0, 25'd0}, 1'b1,
      '{32'd0, 1'b0, EXC_MISS, 26'd0, 26'd0, 64'd0, 25'd0}},
    '{'{OP_WR_ENT, 64'd0, 2'd0, 1'b0, 5'd5, '1, '1, '1, '1}, 1'b0, NoRsp},
    '{'{OP_RD_ENT, 64'd0, 2'd0, 1'b0, 5'd5, 26'd0, 26'd0, 64'd0, 25'd0}, 1'b0, NoRsp},
    '{'{OP_WR_ENT, '1, 2'd3, 1'b1, 5'd31, 26'd0, 26'd0, 64'd0, 25'd0}, 1'b0, NoRsp},
    '{'{OP_RD_ENT, 64'd0, 2'd0, 1'b0, 5'd31, 26'd0, 26'd0, 64'd0, 25'd0}, 1'b0, NoRsp},
    '{'{3'd5, '1, 2'd3, 1'b1, 5'd1, '1, '1, '1, '1}, 1'b1, NoRsp},
    '{'{3'd6, '1, 2'd3, 1'b1, 5'd2, '1, '1, '1, '1}, 1'b1, NoRsp},
    '{'{3'd7, '1, 2'd3, 1'b1, 5'd3, '1, '1, '1, '1}, 1'b1, NoRsp},
    '{'{OP_FETCH, '1, 2'd3, 1'b1, 5'd0, 26'd0, 26'd0, 64'd0, 25'd0}, 1'b0, NoRsp}
  };

  localparam int NumModes = 9;
  localparam int ItemsPerMode = 150;
  localparam mode_t Modes [NumModes] = '{
    '{2'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
    '{2'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'h5A},
    '{2'd1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'hFF},
    '{2'd1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'h01},
    '{2'd2, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h80},
    '{2'd2, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'h7F},
    '{2'd3, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 8'h3C},
    '{2'd2, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 8'hA5},
    '{2'd2, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 8'hFF}
  };

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  mtlb_req_if req_if ();
  mtlb_rsp_if rsp_if ();

  mips_tlb_address_translation u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if.sink),
    .rsp_o       (rsp_if.source)
  );

  // mirror of the MMU state
  logic [63:0] tlb_hi_m [32];
  logic        tlb_g_m  [32];
  logic [25:0] tlb_le_m [32];
  logic [25:0] tlb_lo_m [32];
  logic [24:0] tlb_pm_m [32];
  logic [1:0]  ksu_m;
  logic        erl_m, exl_m, kx_m, sx_m, ux_m;
  logic [7:0]  asid_m;

  rsp_t  exp_rsp_q [$];
  hand_t hand_q [$];
  req_t  drv_req;
  int    tx_pct, rx_pct;
  bit    rx_hold;
  int    n_err, n_checked, n_xfer;

  always begin
    clk_i = 1'b1; #4;
    clk_i = 1'b0; #4;
  end

  function automatic logic [63:0] sx32(logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic [2:0] tlb_search(logic [63:0] va, bit wr, bit wide,
                                            output logic [31:0] pa);
    logic [63:0] pm, vm, om, phys;
    logic [25:0] lo;
    pa = '0;
    for (int i = 0; i < 32; i++) begin
      pm = {39'd0, tlb_pm_m[i]};
      vm = Vpn2Field & ~pm;
      om = (pm >> 1) | 64'hFFF;
      if ((va & vm) != (tlb_hi_m[i] & vm)) continue;
      if (!tlb_g_m[i] && tlb_hi_m[i][7:0] != asid_m) continue;
      if (va[63:62] != tlb_hi_m[i][63:62]) continue;
      lo = ((va & (om + 64'd1)) != 0) ? tlb_lo_m[i] : tlb_le_m[i];
      if (!lo[1]) return EXC_INVALID;
      if (wr && !lo[2]) return EXC_MOD;
      phys = (va & om) | (({38'd0, lo} >> 6) << 12 & ~om);
      pa = phys[31:0];
      return EXC_NONE;
    end
    return wide ? EXC_XMISS : EXC_MISS;
  endfunction

  function automatic logic [2:0] kseg32(logic [63:0] va, bit wr, bit wide,
                                        output logic [31:0] pa, output logic c);
    c = 1'b0;
    pa = '0;
    if (va[31:29] == 3'b100) begin
      c = 1'b1;
      pa = {3'd0, va[28:0]};
      return EXC_NONE;
    end
    if (va[31:29] == 3'b101) begin
      pa = {3'd0, va[28:0]};
      return EXC_NONE;
    end
    return tlb_search(sx32(va[31:0]), wr, wide, pa);
  endfunction

  function automatic logic [2:0] segment_xlate(logic [63:0] va, bit wr,
                                               output logic [31:0] pa, output logic c);
    bit kern, sup, wide;
    kern = (ksu_m == 2'd0) || erl_m || exl_m;
    sup  = !kern && ksu_m == 2'd1;
    wide = kern ? kx_m : sup ? sx_m : ux_m;
    c = 1'b0;
    pa = '0;
    if (kern) begin
      if (!wide) return kseg32(va, wr, 1'b0, pa, c);
      case (va[63:60])
        4'h0: return (va <= 64'h0000_00FF_FFFF_FFFF) ? tlb_search(va, wr, 1'b1, pa) : EXC_ADDR;
        4'h4: return (va <= 64'h4000_00FF_FFFF_FFFF) ? tlb_search(va, wr, 1'b1, pa) : EXC_ADDR;
        4'h8, 4'h9, 4'hA, 4'hB: begin
          if ((va & 64'h07FF_FFFF_0000_0000) != 0) return EXC_ADDR;
          c = (va & 64'h9800_0000_0000_0000) != 64'h9000_0000_0000_0000;
          pa = va[31:0];
          return EXC_NONE;
        end
        4'hC: return (va <= 64'hC000_00FF_7FFF_FFFF) ? tlb_search(va, wr, 1'b1, pa) : EXC_ADDR;
        4'hF: return (va >= KsegBase) ? kseg32(va, wr, 1'b1, pa, c) : EXC_ADDR;
        default: return EXC_ADDR;
      endcase
    end
    if (sup) begin
      if (!wide) begin
        if (va[31] && va[30:29] != 2'b10) return EXC_ADDR;
        return tlb_search(sx32(va[31:0]), wr, 1'b0, pa);
      end
      if (va[63:60] == 4'h0 && va <= 64'h0000_00FF_FFFF_FFFF) return tlb_search(va, wr, 1'b1, pa);
      if (va[63:60] == 4'h4 && va <= 64'h4000_00FF_FFFF_FFFF) return tlb_search(va, wr, 1'b1, pa);
      if ((va & 64'hFFFF_FFFF_E000_0000) == 64'hFFFF_FFFF_C000_0000)
        return tlb_search(va, wr, 1'b1, pa);
      return EXC_ADDR;
    end
    if (!wide) begin
      if (va[31]) return EXC_ADDR;
      return tlb_search(sx32(va[31:0]), wr, 1'b0, pa);
    end
    if (va < 64'h0000_0100_0000_0000) return tlb_search(va, wr, 1'b1, pa);
    return EXC_ADDR;
  endfunction

  // advances the mirrored state and returns the response the request must produce
  function automatic rsp_t mmu_predict(req_t r);
    rsp_t o;
    logic [63:0] va, sz;
    logic [31:0] pa;
    logic c;
    logic [2:0] e;
    logic [24:0] pm;
    o = '0;
    pa = '0;
    c = 1'b0;
    if (r.op <= OP_FETCH) begin
      sz = 64'd1 << r.size;
      va = r.va;
      if (r.op != OP_FETCH && r.al && (va & (sz - 64'd1)) != 0) begin
        e = EXC_ADDR;
      end else begin
        if (r.op == OP_READ && !r.al) va &= ~(sz - 64'd1);
        e = segment_xlate(va, r.op == OP_WRITE, pa, c);
      end
      if (e != EXC_NONE) begin
        pa = '0;
        c = 1'b0;
      end
      o.paddr = pa;
      o.cach = c;
      o.exc = e;
    end else if (r.op == OP_WR_ENT) begin
      pm = r.mask & MaskKeep;
      tlb_le_m[r.idx] = r.le;
      tlb_lo_m[r.idx] = r.lo;
      tlb_pm_m[r.idx] = pm;
      tlb_hi_m[r.idx] = r.hi & HiKeep & ~{39'd0, pm};
      tlb_g_m[r.idx]  = r.le[0] & r.lo[0];
    end else if (r.op == OP_RD_ENT) begin
      o.rle = {tlb_le_m[r.idx][25:1], tlb_g_m[r.idx]};
      o.rlo = {tlb_lo_m[r.idx][25:1], tlb_g_m[r.idx]};
      o.rhi = tlb_hi_m[r.idx] & ~{39'd0, tlb_pm_m[r.idx]};
      o.rmask = tlb_pm_m[r.idx];
    end
    return o;
  endfunction

  function automatic req_t gen_request();
    req_t r;
    int k, i;
    logic [63:0] pm, vm, om;
    r.va   = {$urandom, $urandom};
    r.size = 2'($urandom);
    r.al   = 1'($urandom);
    r.idx  = 5'($urandom);
    r.le   = 26'($urandom);
    r.lo   = 26'($urandom);
    r.hi   = {$urandom, $urandom};
    r.mask = 25'($urandom);
    k = $urandom_range(99);
    if (k < 4) begin
      r.op = 3'($urandom_range(7, 5));
    end else if (k < 20) begin
      r.op = OP_WR_ENT;
      if ($urandom_range(99) < 85) begin
        if ($urandom_range(1)) begin
          r.hi = sx32($urandom);
        end else begin
          r.hi[63:62] = ($urandom_range(2) == 2) ? 2'b11 : 2'($urandom_range(1));
        end
        if ($urandom_range(1)) r.hi[7:0] = asid_m;
        r.le[1] = $urandom_range(99) < 85;
        r.lo[1] = $urandom_range(99) < 85;
        if ($urandom_range(99) < 70) r.lo[0] = r.le[0];
        r.mask = PageMasks[$urandom_range(6)];
      end
    end else if (k < 28) begin
      r.op = OP_RD_ENT;
    end else begin
      r.op = 3'($urandom_range(2));
      k = $urandom_range(9);
      if (k <= 4) begin
        // aim at a resident entry
        i = $urandom_range(31);
        pm = {39'd0, tlb_pm_m[i]};
        vm = Vpn2Field & ~pm;
        om = (pm >> 1) | 64'hFFF;
        r.va = (tlb_hi_m[i] & vm) | ({$urandom, $urandom} & ((om << 1) | 64'd1));
        r.va[63:62] = tlb_hi_m[i][63:62];
        r.va[61:40] = (tlb_hi_m[i][63:62] == 2'b11) ? '1 : '0;
        if ($urandom_range(1)) r.va &= ~((64'd1 << r.size) - 64'd1);
      end else if (k == 5) begin
        r.va = sx32({2'b10, 1'($urandom), 29'($urandom)});
      end else if (k == 6) begin
        r.va = {2'b10, 3'($urandom), 27'd0, $urandom};
        if ($urandom_range(9) == 0) r.va[58:32] = 27'($urandom);
      end else if (k == 7) begin
        r.va = sx32($urandom);
      end else if (k == 9) begin
        r.va = EdgeAddrs[$urandom_range(10)];
      end
    end
    return r;
  endfunction

  task automatic send_request(req_t r, logic typed, rsp_t ex);
    while (tx_pct != 0 && $urandom_range(99) < tx_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    drv_req = r;
    hand_q.push_back('{typed, ex});
    req_if.opcode         <= r.op;
    req_if.vaddr          <= r.va;
    req_if.size_log2      <= r.size;
    req_if.aligned_access <= r.al;
    req_if.entry_index    <= r.idx;
    req_if.lo_even        <= r.le;
    req_if.lo_odd         <= r.lo;
    req_if.hi_value       <= r.hi;
    req_if.mask_value     <= r.mask;
    req_if.valid          <= 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [7:0] d);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= d;
    case (idx)
      CFG_KSU:  ksu_m  = d[1:0];
      CFG_ERL:  erl_m  = d[0];
      CFG_EXL:  exl_m  = d[0];
      CFG_KX:   kx_m   = d[0];
      CFG_SX:   sx_m   = d[0];
      CFG_UX:   ux_m   = d[0];
      CFG_ASID: asid_m = d;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (exp_rsp_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic chk(string fld, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, fld, e, a);
      n_err++;
    end
  endtask

  // transfer on the request side
  always @(posedge clk_i) begin
    hand_t h;
    rsp_t p;
    if (rst_ni && req_if.valid && req_if.ready) begin
      h = hand_q.pop_front();
      p = mmu_predict(drv_req);
      exp_rsp_q.push_back(h.typed ? h.ex : p);
      n_xfer++;
    end
  end

  // transfer on the response side
  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (exp_rsp_q.size() == 0) begin
        $display("%0t: response with none pending, paddr %h exc %0d", $time,
                 rsp_if.paddr, rsp_if.exc_code);
        n_err++;
      end else begin
        e = exp_rsp_q.pop_front();
        n_checked++;
        chk("paddr", e.paddr, rsp_if.paddr);
        chk("cacheable", e.cach, rsp_if.cacheable);
        chk("exc_code", e.exc, rsp_if.exc_code);
        chk("rd_lo_even", e.rle, rsp_if.rd_lo_even);
        chk("rd_lo_odd", e.rlo, rsp_if.rd_lo_odd);
        chk("rd_hi", e.rhi, rsp_if.rd_hi);
        chk("rd_mask", e.rmask, rsp_if.rd_mask);
      end
    end
  end

  always @(negedge clk_i) begin
    rsp_if.ready <= !rx_hold && (rx_pct == 0 || $urandom_range(99) >= rx_pct);
  end

  initial begin
    #5_000_000;
    $display("mips_tlb_address_translation test failed");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    req_if.valid = 1'b0;
    req_if.opcode = '0;
    req_if.vaddr = '0;
    req_if.size_log2 = '0;
    req_if.aligned_access = 1'b0;
    req_if.entry_index = '0;
    req_if.lo_even = '0;
    req_if.lo_odd = '0;
    req_if.hi_value = '0;
    req_if.mask_value = '0;
    rsp_if.ready = 1'b0;
    tx_pct = 0;
    rx_pct = 0;
    rx_hold = 1'b0;
    n_err = 0;
    n_checked = 0;
    n_xfer = 0;
    ksu_m = 2'd0; erl_m = 1'b1; exl_m = 1'b0;
    kx_m = 1'b0; sx_m = 1'b0; ux_m = 1'b0; asid_m = 8'd0;
    for (int i = 0; i < 32; i++) begin
      tlb_hi_m[i] = Vpn2Field | 64'hFF;
      tlb_g_m[i]  = 1'b1;
      tlb_le_m[i] = '0;
      tlb_lo_m[i] = '0;
      tlb_pm_m[i] = '0;
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int n = 0; n < NumRows; n++) begin
      send_request(DirRows[n].rq, DirRows[n].typed, DirRows[n].ex);
    end
    req_if.valid <= 1'b0;

    for (int m = 0; m < NumModes; m++) begin
      wait_drained();
      tx_pct = (m < 3) ? 21 : (m < 6) ? 88 : 0;
      rx_pct = (m < 3) ? 88 : (m < 6) ? 21 : 0;
      cfg_write(CFG_KSU,  {6'd0, Modes[m].ksu});
      cfg_write(CFG_ERL,  {7'd0, Modes[m].erl});
      cfg_write(CFG_EXL,  {7'd0, Modes[m].exl});
      cfg_write(CFG_KX,   {7'd0, Modes[m].kx});
      cfg_write(CFG_SX,   {7'd0, Modes[m].sx});
      cfg_write(CFG_UX,   {7'd0, Modes[m].ux});
      cfg_write(CFG_ASID, Modes[m].asid);
      cfg_we <= 1'b0;
      @(negedge clk_i);
      if (m == 6) begin
        // stall the response side while requests keep coming
        fork
          begin
            rx_hold = 1'b1;
            repeat (400) @(posedge clk_i);
            rx_hold = 1'b0;
          end
        join_none
      end
      for (int n = 0; n < ItemsPerMode; n++) begin
        send_request(gen_request(), 1'b0, NoRsp);
      end
      req_if.valid <= 1'b0;
    end

    while (exp_rsp_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    $display("Covered %0d request transfers, %0d responses checked, %0d mode settings",
             n_xfer, n_checked, NumModes);
    $display("  (mapped hits and misses, unmapped segments, alignment, entry read/write)");
    if (n_err == 0) begin
      $display("mips_tlb_address_translation test passed");
    end else begin
      $display("mips_tlb_address_translation test failed");
    end
    $finish;
  end

endmodule
